>>> rtl/dic_pkg.sv
// ----------------------------------------------------------------------------
// dic_pkg
// Types and codes shared by the delta instruction decoder modules.
// ----------------------------------------------------------------------------
package dic_pkg;

  typedef enum logic [1:0] {
    KIND_COPY    = 2'd0,
    KIND_LITERAL = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_COPY_OOB  = 3'd1;
  localparam logic [2:0] ERR_INS_TRUNC = 3'd2;
  localparam logic [2:0] ERR_ZERO_CMD  = 3'd3;
  localparam logic [2:0] ERR_SIZE      = 3'd4;
  localparam logic [2:0] ERR_VARINT    = 3'd5;

  localparam logic [23:0] COPY_MAX = 24'h010000;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] offset;
    logic [16:0] length;
    logic [7:0]  literal;
    logic [2:0]  err;
    logic        last;
  } result_t;

  // Up to two results per byte: r0 first, r1 only together with r0.
  typedef struct packed {
    logic    vld0;
    logic    vld1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

>>> rtl/dic_core.sv
// ----------------------------------------------------------------------------
// dic_core
// Delta stream state and per-byte decode: varint headers, copy and insert
// commands, end-of-stream status.
// ----------------------------------------------------------------------------
module dic_core #(
  parameter int unsigned SIZE_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     byte_i,
  input  logic           end_i,
  input  logic [31:0]    base_len_i,
  output dic_pkg::push_t push_o
);
  import dic_pkg::*;

  localparam int unsigned ShW = $clog2(SIZE_WIDTH);
  localparam int unsigned PW  = SIZE_WIDTH + 1;

  localparam logic [2:0] PH_SRC  = 3'd0;
  localparam logic [2:0] PH_TGT  = 3'd1;
  localparam logic [2:0] PH_CMD  = 3'd2;
  localparam logic [2:0] PH_COPY = 3'd3;
  localparam logic [2:0] PH_INS  = 3'd4;

  logic [2:0]            phase_q, phase_d;
  logic [ShW-1:0]        shift_q, shift_d;
  logic [SIZE_WIDTH-1:0] tgt_q, tgt_d;
  logic [6:0]            pend_q, pend_d;
  logic [31:0]           off_q, off_d;
  logic [23:0]           len_q, len_d;
  logic [6:0]            ins_q, ins_d;
  logic [PW-1:0]         prod_q, prod_d;
  logic                  disc_q, disc_d;

  logic [2:0]            err;
  logic                  copy_fin;
  logic                  prim_vld;
  result_t               prim;
  result_t               stat;
  logic                  stat_vld;
  logic [2:0]            idx;
  logic [23:0]           len_eff;
  logic [32:0]           copy_end;
  logic [16:0]           add_amt;
  logic                  add_en;
  logic [PW:0]           prod_sum;
  logic [SIZE_WIDTH+6:0] vwide;

  always_comb begin
    phase_d  = phase_q;
    shift_d  = shift_q;
    tgt_d    = tgt_q;
    pend_d   = pend_q;
    off_d    = off_q;
    len_d    = len_q;
    ins_d    = ins_q;
    disc_d   = disc_q;
    err      = ERR_NONE;
    copy_fin = 1'b0;
    prim_vld = 1'b0;
    prim     = '0;
    add_en   = 1'b0;
    add_amt  = '0;
    idx      = 3'd6;
    vwide    = (SIZE_WIDTH + 7)'(byte_i[6:0]) << shift_q;

    for (int i = 5; i >= 0; i--) begin
      if (pend_q[i]) begin
        idx = 3'(i);
      end
    end

    if (!disc_q) begin
      case (phase_q)
        PH_CMD: begin
          if (byte_i[7]) begin
            pend_d = byte_i[6:0];
            off_d  = '0;
            len_d  = '0;
            if (byte_i[6:0] == 7'd0) begin
              copy_fin = 1'b1;
            end else begin
              phase_d = PH_COPY;
            end
          end else if (byte_i != 8'd0) begin
            ins_d   = byte_i[6:0];
            phase_d = PH_INS;
          end else begin
            err = ERR_ZERO_CMD;
          end
        end
        PH_COPY: begin
          pend_d = pend_q & ~(7'd1 << idx);
          if (idx < 3'd4) begin
            off_d = off_q | (32'(byte_i) << {idx[1:0], 3'd0});
          end else begin
            len_d = len_q | (24'(byte_i) << {idx[1:0], 3'd0});
          end
          if (pend_d == 7'd0) begin
            copy_fin = 1'b1;
          end
        end
        PH_INS: begin
          prim_vld     = 1'b1;
          prim.kind    = KIND_LITERAL;
          prim.literal = byte_i;
          add_en       = 1'b1;
          add_amt      = 17'd1;
          ins_d        = ins_q - 7'd1;
          if (ins_d == 7'd0) begin
            phase_d = PH_CMD;
          end
        end
        default: begin
          if (|vwide[SIZE_WIDTH+6:SIZE_WIDTH]) begin
            err = ERR_VARINT;
          end else begin
            if (phase_q == PH_TGT) begin
              tgt_d = tgt_q | vwide[SIZE_WIDTH-1:0];
            end
            if (byte_i[7]) begin
              if ((ShW + 1)'(shift_q) + (ShW + 1)'(7) >= (ShW + 1)'(SIZE_WIDTH)) begin
                err = ERR_VARINT;
              end else begin
                shift_d = shift_q + ShW'(7);
              end
            end else begin
              phase_d = (phase_q == PH_TGT) ? PH_CMD : PH_TGT;
              shift_d = '0;
            end
          end
        end
      endcase
    end

    len_eff  = (len_d == 24'd0) ? COPY_MAX : len_d;
    copy_end = {1'b0, off_d} + 33'(len_eff);
    if (copy_fin) begin
      if (len_eff > COPY_MAX || copy_end > {1'b0, base_len_i}) begin
        err = ERR_COPY_OOB;
      end else begin
        prim_vld    = 1'b1;
        prim.kind   = KIND_COPY;
        prim.offset = off_d;
        prim.length = len_eff[16:0];
        add_en      = 1'b1;
        add_amt     = len_eff[16:0];
        phase_d     = PH_CMD;
      end
    end

    prod_sum = {1'b0, prod_q} + (PW + 1)'(add_amt);
    if (!add_en) begin
      prod_d = prod_q;
    end else if (prod_sum[PW]) begin
      prod_d = '1;
    end else begin
      prod_d = prod_sum[PW-1:0];
    end

    stat      = '0;
    stat.last = 1'b1;
    stat_vld  = !disc_q && (err != ERR_NONE || end_i);
    if (err != ERR_NONE) begin
      stat.kind = KIND_ERROR;
      stat.err  = err;
    end else if (phase_d == PH_CMD) begin
      if (prod_d == PW'(tgt_d)) begin
        stat.kind = KIND_DONE;
      end else begin
        stat.kind = KIND_ERROR;
        stat.err  = ERR_SIZE;
      end
    end else begin
      stat.kind = KIND_ERROR;
      stat.err  = (phase_d == PH_INS) ? ERR_INS_TRUNC : ERR_VARINT;
    end

    if (!disc_q && err != ERR_NONE) begin
      disc_d = 1'b1;
    end
    if (end_i) begin
      phase_d = PH_SRC;
      shift_d = '0;
      tgt_d   = '0;
      pend_d  = '0;
      off_d   = '0;
      len_d   = '0;
      ins_d   = '0;
      prod_d  = '0;
      disc_d  = 1'b0;
    end

    push_o = '0;
    if (step_i) begin
      if (prim_vld) begin
        push_o.vld0 = 1'b1;
        push_o.r0   = prim;
        push_o.vld1 = stat_vld;
        push_o.r1   = stat;
      end else begin
        push_o.vld0 = stat_vld;
        push_o.r0   = stat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SRC;
      shift_q <= '0;
      tgt_q   <= '0;
      pend_q  <= '0;
      off_q   <= '0;
      len_q   <= '0;
      ins_q   <= '0;
      prod_q  <= '0;
      disc_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      tgt_q   <= tgt_d;
      pend_q  <= pend_d;
      off_q   <= off_d;
      len_q   <= len_d;
      ins_q   <= ins_d;
      prod_q  <= prod_d;
      disc_q  <= disc_d;
    end
  end

endmodule

>>> rtl/dic_rq.sv
// ----------------------------------------------------------------------------
// dic_rq
// Three-entry result queue; takes up to two results per cycle, shows one.
// ----------------------------------------------------------------------------
module dic_rq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dic_pkg::push_t   push_i,
  input  logic             pop_i,
  output dic_pkg::result_t head_o,
  output logic             valid_o,
  output logic             room_o
);
  import dic_pkg::*;

  localparam int unsigned Depth = 3;
  localparam int unsigned IdxW  = 2;

  result_t         q_q [Depth];
  result_t         q_d [Depth];
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] base;

  always_comb begin
    base = cnt_q - IdxW'(pop_i);
    for (int i = 0; i < Depth; i++) begin
      if (IdxW'(i) < base) begin
        q_d[i] = pop_i ? q_q[IdxW'((i + 1) % Depth)] : q_q[i];
      end else if (IdxW'(i) == base && push_i.vld0) begin
        q_d[i] = push_i.r0;
      end else if (IdxW'(i) == base + IdxW'(1) && push_i.vld1) begin
        q_d[i] = push_i.r1;
      end else begin
        q_d[i] = q_q[i];
      end
    end
    cnt_d = base + IdxW'(push_i.vld0) + IdxW'(push_i.vld1);
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign head_o  = q_q[0];
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= IdxW'(1));

endmodule

>>> rtl/delta_instruction_decoder.sv
// ----------------------------------------------------------------------------
// delta_instruction_decoder
// Decodes a packfile delta stream into copy descriptors, literal bytes and a
// final status.
// ----------------------------------------------------------------------------
// One delta byte is taken per cycle while the result queue has room. A byte
// passes an input register, is decoded combinationally and lands in a
// three-entry result queue. A byte that gives two results (a copy or literal
// on the final byte of a stream) holds off the next transfer while the queue
// drains. base_length, written through cfg_we_i / cfg_wdata_i, persists across
// streams; the user must write it between streams (not enforced by the block).
// After an error, bytes are dropped up to and including the end byte.
module delta_instruction_decoder #(
  parameter int unsigned SIZE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] delta_byte
  input  logic        s_axis_tlast_i,   // delta_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // copy_offset, copy_length, literal_value,
                                        // error_code, zero pad
  output logic [1:0]  m_axis_tuser_o,   // result_kind
  output logic        m_axis_tlast_o    // run_last
);
  import dic_pkg::*;

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_end_q;
  logic [31:0] base_len_q;
  logic        room;
  logic        step;
  push_t       push;
  result_t     head;

  assign step            = in_vld_q && room;
  assign s_axis_tready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      base_len_q <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (cfg_we_i) begin
        base_len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_end_q  <= s_axis_tlast_i;
    end
  end

  dic_core #(
    .SIZE_WIDTH(SIZE_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .end_i      (in_end_q),
    .base_len_i (base_len_q),
    .push_o     (push)
  );

  dic_rq u_rq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tvalid_o && m_axis_tready_i),
    .head_o  (head),
    .valid_o (m_axis_tvalid_o),
    .room_o  (room)
  );

  assign m_axis_tdata_o = {4'd0, head.err, head.literal, head.length, head.offset};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

endmodule

>>> rtl/dic_checker.sv
// ----------------------------------------------------------------------------
// dic_checker
// Port-level checks for the delta instruction decoder, bound to the top.
// ----------------------------------------------------------------------------
module dic_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  import dic_pkg::*;

  logic is_status;
  assign is_status = (m_axis_tuser_o == KIND_DONE) || (m_axis_tuser_o == KIND_ERROR);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == is_status))
    else $error("tlast does not match a status result");

  a_copy_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_COPY |->
      m_axis_tdata_o[48:32] != 17'd0 && m_axis_tdata_o[48:32] <= 17'h10000)
    else $error("copy length out of range");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ((m_axis_tuser_o == KIND_ERROR) == (m_axis_tdata_o[59:57] != ERR_NONE)))
    else $error("error code does not match result kind");

endmodule

bind delta_instruction_decoder dic_checker u_dic_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
